FILE: hw/rtl/printable_string_scanner_core_defines.svh
// ----------------------------------------------------------------------------
// printable string scanner assertion macros
// shared assertion helpers, active in simulation and empty for synthesis
// ----------------------------------------------------------------------------
`ifndef PRINTABLE_STRING_SCANNER_CORE_DEFINES_SVH
`define PRINTABLE_STRING_SCANNER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// property that must hold at every clock edge outside reset
`define PSS_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pss assertion failed");

// condition in one cycle implies a condition in the next
`define PSS_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("pss assertion failed");

`else

`define PSS_ASSERT(label, prop)
`define PSS_ASSERT_NEXT(label, pre, post)

`endif

`endif

FILE: hw/rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// shared types and constants of the printable string scanner
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 64;
    localparam int CFG_LEN_W = 16;
    localparam int LEN_W     = CFG_LEN_W + 1;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CFG_LEN_W-1:0] cfg_len_t;
    typedef logic [LEN_W-1:0]     len_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_MIN_LENGTH = 1'b0,
        REG_MAX_LENGTH = 1'b1
    } cfg_reg_t;

    localparam cfg_len_t MIN_LENGTH_RESET = 16'd3;
    localparam cfg_len_t MAX_LENGTH_RESET = 16'd255;

    // outcome of judging one byte
    typedef struct packed {
        len_t run;
        logic wide;
        logic hit;
        len_t len;
        logic hit_wide;
    } judge_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pss_if.sv
// ----------------------------------------------------------------------------
// pss channel interfaces
// byte request, hit result and configuration write channels
// ----------------------------------------------------------------------------
`default_nettype none

// byte request channel
interface pss_scan_if;
    import pss_pkg::*;
    logic  valid;
    logic  ready;
    byte_t data_byte;
    addr_t byte_address;
    logic  last_in_buffer;

    modport source (output valid, output data_byte, output byte_address,
                    output last_in_buffer, input ready);
    modport sink   (input valid, input data_byte, input byte_address,
                    input last_in_buffer, output ready);
endinterface

// hit result channel
interface pss_hit_if;
    import pss_pkg::*;
    logic  valid;
    logic  ready;
    addr_t hit_address;
    len_t  hit_length;
    logic  wide_hit;

    modport source (output valid, output hit_address, output hit_length,
                    output wide_hit, input ready);
    modport sink   (input valid, input hit_address, input hit_length,
                    input wide_hit, output ready);
endinterface

// configuration write channel
interface pss_cfg_if;
    import pss_pkg::*;
    logic     valid;
    logic     ready;
    cfg_reg_t index;
    cfg_len_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/printable_string_scanner_core.sv
// ----------------------------------------------------------------------------
// printable_string_scanner_core
// finds runs of printable bytes in a byte stream and reports string hits
// ----------------------------------------------------------------------------
// The core takes one byte per clock unless the hit channel stalls it, and
// reports at most one hit per byte: one register stage judges the byte against
// the run counter and the two-byte lookahead line, the second forms the 64-bit
// start address. Back-pressure on the hit channel stalls both stages together.
// min_length and max_length are written through the configuration channel,
// which is always ready; write them only while no bytes are in flight.
`default_nettype none

`include "printable_string_scanner_core_defines.svh"

module printable_string_scanner_core (
    input  wire       clk,
    input  wire       rst_n,
    pss_scan_if.sink  scan,
    pss_hit_if.source hit,
    pss_cfg_if.sink   cfg
);
    import pss_pkg::*;

    // configuration registers
    cfg_len_t min_length_reg;
    cfg_len_t max_length_reg;

    // scan state
    len_t       run_reg,  run_next;
    logic       wide_reg, wide_next;
    logic [1:0] cnt_reg,  cnt_next;
    byte_t      d0_reg, d0_next, d1_reg, d1_next;
    addr_t      da0_reg, da0_next, da1_reg, da1_next;

    // judge stage result
    logic  hv_reg;
    addr_t ha_reg;
    len_t  hl_reg;
    logic  hw_reg;

    // output stage
    logic  ov_reg;
    addr_t oa_reg;
    len_t  ol_reg;
    logic  ow_reg;

    logic   adv;
    logic   accept;
    judge_t j0, j1, j2;
    len_t   run_a;
    logic   wide_a;
    byte_t  e0, e1;
    addr_t  ea0, ea1;
    logic   two;
    logic   h0, h1, h2;
    logic   hit_any;
    addr_t  hit_addr;
    len_t   hit_len;
    logic   hit_wide;
    addr_t  len_ext;
    addr_t  start_addr;

    function automatic logic is_text(byte_t b);
        return ((b >= 8'h20) && (b <= 8'h7e)) || (b == 8'h09);
    endfunction

    // judge one byte against the running count
    function automatic judge_t judge(len_t run, logic wide, byte_t b, logic look,
                                     byte_t n1, byte_t n2, cfg_len_t minl,
                                     cfg_len_t maxl);
        judge_t j;
        len_t   maxx;
        maxx       = {1'b0, maxl};
        j.run      = run;
        j.wide     = wide;
        j.hit      = 1'b0;
        j.len      = run;
        j.hit_wide = wide;
        if (is_text(b))
        begin
            if (run <= maxx)
                j.run = run + len_t'(1);
            else
                j.run = '0;
        end
        else
        begin
            if ((run != '0) && look && (b == 8'h00) && (n1 != 8'h00) && (n2 == 8'h00))
                j.wide = 1'b1;
            j.hit = (run >= {1'b0, minl}) && ((maxl == '0) || (run <= maxx))
                    && (run > len_t'(2));
            j.hit_wide = j.wide;
            j.run      = '0;
            j.wide     = 1'b0;
        end
        return j;
    endfunction

    // handshakes
    assign adv       = !ov_reg || hit.ready;
    assign scan.ready = adv;
    assign accept    = scan.valid && adv;
    assign cfg.ready = 1'b1;

    // delay line and judging of up to three bytes
    always_comb
    begin
        j0 = judge(run_reg, wide_reg, d0_reg, 1'b1, d1_reg, scan.data_byte,
                   min_length_reg, max_length_reg);
        if (cnt_reg == 2'd2)
        begin
            run_a  = j0.run;
            wide_a = j0.wide;
            e0     = d1_reg;
            ea0    = da1_reg;
            two    = 1'b1;
        end
        else if (cnt_reg == 2'd1)
        begin
            run_a  = run_reg;
            wide_a = wide_reg;
            e0     = d0_reg;
            ea0    = da0_reg;
            two    = 1'b1;
        end
        else
        begin
            run_a  = run_reg;
            wide_a = wide_reg;
            e0     = scan.data_byte;
            ea0    = scan.byte_address;
            two    = 1'b0;
        end
        e1  = scan.data_byte;
        ea1 = scan.byte_address;

        j1 = judge(run_a, wide_a, e0, 1'b0, 8'h00, 8'h00,
                   min_length_reg, max_length_reg);
        j2 = judge(j1.run, j1.wide, e1, 1'b0, 8'h00, 8'h00,
                   min_length_reg, max_length_reg);

        // first hit of the step wins
        h0 = (cnt_reg == 2'd2) && j0.hit;
        h1 = scan.last_in_buffer && j1.hit;
        h2 = scan.last_in_buffer && two && j2.hit;
        hit_any = h0 || h1 || h2;
        if (h0)
        begin
            hit_addr = da0_reg;
            hit_len  = j0.len;
            hit_wide = j0.hit_wide;
        end
        else if (h1)
        begin
            hit_addr = ea0;
            hit_len  = j1.len;
            hit_wide = j1.hit_wide;
        end
        else
        begin
            hit_addr = ea1;
            hit_len  = j2.len;
            hit_wide = j2.hit_wide;
        end

        // next state, cleared at buffer end
        d0_next  = e0;
        d1_next  = e1;
        da0_next = ea0;
        da1_next = ea1;
        if (scan.last_in_buffer)
        begin
            run_next  = '0;
            wide_next = 1'b0;
            cnt_next  = 2'd0;
        end
        else
        begin
            run_next  = run_a;
            wide_next = wide_a;
            cnt_next  = two ? 2'd2 : 2'd1;
        end
    end

    // start address of the hit
    assign len_ext    = addr_t'(hl_reg);
    assign start_addr = hw_reg ? (ha_reg - (len_ext << 1) + addr_t'(1))
                               : (ha_reg - len_ext);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_length_reg <= MIN_LENGTH_RESET;
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MIN_LENGTH: min_length_reg <= cfg.data;
                REG_MAX_LENGTH: max_length_reg <= cfg.data;
                default:        min_length_reg <= min_length_reg;
            endcase
        end
    end

    // scan state and control of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= '0;
            wide_reg <= 1'b0;
            cnt_reg  <= 2'd0;
            hv_reg   <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                run_reg  <= run_next;
                wide_reg <= wide_next;
                cnt_reg  <= cnt_next;
            end
            if (adv)
            begin
                hv_reg <= accept && hit_any;
                ov_reg <= hv_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d0_reg  <= d0_next;
            d1_reg  <= d1_next;
            da0_reg <= da0_next;
            da1_reg <= da1_next;
        end
        if (adv)
        begin
            ha_reg <= hit_addr;
            hl_reg <= hit_len;
            hw_reg <= hit_wide;
            oa_reg <= start_addr;
            ol_reg <= hl_reg;
            ow_reg <= hw_reg;
        end
    end

    // result channel
    assign hit.valid       = ov_reg;
    assign hit.hit_address = oa_reg;
    assign hit.hit_length  = ol_reg;
    assign hit.wide_hit    = ow_reg;

    // checks
    `PSS_ASSERT(a_cnt_range, cnt_reg != 2'd3)
    `PSS_ASSERT_NEXT(a_buffer_end_clears, accept && scan.last_in_buffer,
                     (run_reg == '0) && (cnt_reg == 2'd0) && !wide_reg)
    `PSS_ASSERT_NEXT(a_judge_holds, hv_reg && !adv, hv_reg)
    `PSS_ASSERT(a_hit_length, !ov_reg || (ol_reg > len_t'(2)))

endmodule

`default_nettype wire

FILE: dv/pss_scan_tb_pkg.sv
// ----------------------------------------------------------------------------
// pss_scan_tb_pkg
// string hit tracker for the printable string scanner testbench: follows the
// byte stream with its own copy of the scanner state and keeps the hits that
// the core has still to report
// ----------------------------------------------------------------------------
package pss_scan_tb_pkg;

    import pss_pkg::*;

    typedef struct packed {
        addr_t address;
        len_t  length;
        logic  wide;
    } string_hit_t;

    class string_hit_tracker;

        // length limits as last written
        cfg_len_t min_len;
        cfg_len_t max_len;

        // scan state: current run, wide mark and the two-byte lookahead line
        len_t  run_count;
        bit    wide_flag;
        byte_t held_byte [2];
        addr_t held_addr [2];
        int    held_cnt;

        string_hit_t pending_hits [$];

        int n_bytes;
        int n_hits;
        int n_wide;
        int n_errors;

        function new();
            min_len  = MIN_LENGTH_RESET;
            max_len  = MAX_LENGTH_RESET;
            n_bytes  = 0;
            n_hits   = 0;
            n_wide   = 0;
            n_errors = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            run_count    = '0;
            wide_flag    = 1'b0;
            held_byte[0] = '0;
            held_byte[1] = '0;
            held_addr[0] = '0;
            held_addr[1] = '0;
            held_cnt     = 0;
        endfunction

        function void set_register(cfg_reg_t idx, cfg_len_t val);
            case (idx)
                REG_MIN_LENGTH: min_len = val;
                REG_MAX_LENGTH: max_len = val;
                default: ;
            endcase
        endfunction

        // printable ascii or tab
        static function bit is_text(byte_t b);
            return (b >= 8'h20 && b <= 8'h7E) || b == 8'h09;
        endfunction

        // settle one byte once its lookahead is known (or known to be absent)
        function void judge_byte(byte_t b, addr_t a, bit look, byte_t n1, byte_t n2,
                                 inout bit found, inout string_hit_t h);
            addr_t len64;
            if (is_text(b))
            begin
                // past max_length + 1 the count restarts without a report
                if (run_count < ({1'b0, max_len} + 17'd1))
                    run_count = run_count + 17'd1;
                else
                    run_count = '0;
                return;
            end
            // terminator, then a non-zero byte, then zero: wide form
            if (run_count != 0 && look && b == 8'h00 && n1 != 8'h00 && n2 == 8'h00)
                wide_flag = 1'b1;
            if (run_count >= {1'b0, min_len}
                && (max_len == 0 || run_count <= {1'b0, max_len})
                && run_count > 17'd2 && !found)
            begin
                len64 = addr_t'(run_count);
                h.address = wide_flag ? (a - (len64 << 1) + 64'd1) : (a - len64);
                h.length  = run_count;
                h.wide    = wide_flag;
                found     = 1'b1;
            end
            run_count = '0;
            wide_flag = 1'b0;
        endfunction

        // note one accepted byte request and queue the hit it causes, if any
        function void scan_byte(byte_t b, addr_t a, bit last);
            bit          found;
            string_hit_t h;
            found = 1'b0;
            h     = '0;
            n_bytes++;
            if (held_cnt >= 2)
            begin
                judge_byte(held_byte[0], held_addr[0], 1'b1, held_byte[1], b, found, h);
                held_byte[0] = held_byte[1];
                held_addr[0] = held_addr[1];
                held_cnt     = 1;
            end
            held_byte[held_cnt] = b;
            held_addr[held_cnt] = a;
            held_cnt++;
            // buffer end: flush the line without lookahead, drop an open run
            if (last)
            begin
                for (int k = 0; k < held_cnt; k++)
                    judge_byte(held_byte[k], held_addr[k], 1'b0, 8'h00, 8'h00, found, h);
                clear_scan();
            end
            if (found)
                pending_hits.push_back(h);
        endfunction

        function void report_error(string what, string_hit_t got, string_hit_t want);
            n_errors++;
            if (n_errors <= 10)
                $display("[%0t] %s: addr exp %h got %h, len exp %0d got %0d, wide exp %0b got %0b",
                         $time, what, want.address, got.address, want.length, got.length,
                         want.wide, got.wide);
        endfunction

        // compare one accepted hit with the oldest one still owed
        function void check_hit(string_hit_t got);
            string_hit_t want;
            if (pending_hits.size() == 0)
            begin
                report_error("hit with none owed", got, '0);
                return;
            end
            want = pending_hits.pop_front();
            n_hits++;
            if (got.wide)
                n_wide++;
            if (got.address !== want.address || got.length !== want.length
                || got.wide !== want.wide)
                report_error("hit mismatch", got, want);
        endfunction

        function void check_leftovers();
            if (pending_hits.size() != 0)
            begin
                n_errors += pending_hits.size();
                $display("%0d expected hits never arrived", pending_hits.size());
            end
        endfunction

    endclass

endpackage

FILE: dv/tb_printable_string_scanner_core.sv
// ----------------------------------------------------------------------------
// tb_printable_string_scanner_core
// drives byte buffers into the scanner, writes the length limits between
// phases and checks every string hit against the tracker's predicted hits,
// under random gaps on the request side and random back-pressure on hits
// ----------------------------------------------------------------------------
module tb_printable_string_scanner_core;

    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;
    import pss_scan_tb_pkg::*;

    localparam int PHASES       = 9;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 5000;

    // length limits and random byte budget per phase, extremes included
    cfg_len_t phase_min [PHASES] = '{16'd3, 16'd0, 16'd1, 16'd4, 16'd0,
                                     16'd65535, 16'd5, 16'd3, 16'd2};
    cfg_len_t phase_max [PHASES] = '{16'd255, 16'd0, 16'd4, 16'd4, 16'd8,
                                     16'd65535, 16'd0, 16'd20, 16'd65535};
    int phase_items [PHASES] = '{120, 120, 120, 120, 120, 40, 120, 120, 120};

    logic clk;
    logic rst_n;

    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    byte_t scan_bytes [$];

    string_hit_tracker tracker;

    pss_scan_if scan_ch ();
    pss_hit_if  hit_ch ();
    pss_cfg_if  cfg_ch ();

    printable_string_scanner_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .scan  (scan_ch),
        .hit   (hit_ch),
        .cfg   (cfg_ch)
    );

    always #1 clk = ~clk;

    // hit side: check accepted hits, random back-pressure
    always @(posedge clk)
    begin
        if (rst_n && hit_ch.valid && hit_ch.ready)
            tracker.check_hit('{hit_ch.hit_address, hit_ch.hit_length, hit_ch.wide_hit});
        hit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog on cycles with no request, hit or register write taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((scan_ch.valid && scan_ch.ready) || (hit_ch.valid && hit_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // one byte request, with random gaps before it
    task automatic send_byte(input byte_t b, input addr_t a, input bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            scan_ch.valid <= 1'b0;
            @(posedge clk);
        end
        scan_ch.valid          <= 1'b1;
        scan_ch.data_byte      <= b;
        scan_ch.byte_address   <= a;
        scan_ch.last_in_buffer <= last;
        @(posedge clk);
        while (!scan_ch.ready)
            @(posedge clk);
        tracker.scan_byte(b, a, last);
    endtask

    // whole buffer from scan_bytes, addresses counting up from base
    task automatic send_buffer(input addr_t base);
        for (int i = 0; i < scan_bytes.size(); i++)
            send_byte(scan_bytes[i], base + addr_t'(i), i == scan_bytes.size() - 1);
    endtask

    // wait for every owed hit, then let the pipeline empty
    task automatic drain();
        scan_ch.valid <= 1'b0;
        while (tracker.pending_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_lengths(input cfg_len_t min_v, input cfg_len_t max_v);
        cfg_reg_t idx;
        cfg_len_t val;
        for (int r = 0; r < 2; r++)
        begin
            idx = (r == 0) ? REG_MIN_LENGTH : REG_MAX_LENGTH;
            val = (r == 0) ? min_v : max_v;
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= val;
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            tracker.set_register(idx, val);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic byte_t rand_text();
        if ($urandom_range(9) == 0)
            return 8'h09;
        return byte_t'($urandom_range(8'h7E, 8'h20));
    endfunction

    function automatic byte_t rand_nontext();
        byte_t b;
        do
            b = byte_t'($urandom_range(255));
        while (string_hit_tracker::is_text(b));
        return b;
    endfunction

    // text-like buffer: runs of printable bytes with assorted terminators,
    // wide patterns among them; now and then plain noise
    function automatic void fill_random_buffer();
        int cap;
        int run_len;
        int kind;
        scan_bytes.delete();
        if ($urandom_range(4) == 0)
        begin
            repeat ($urandom_range(1, 12)) scan_bytes.push_back(byte_t'($urandom));
            return;
        end
        if (tracker.max_len == 0)
            cap = 10;
        else if (tracker.max_len > 37)
            cap = 40;
        else
            cap = tracker.max_len + 3;
        repeat ($urandom_range(1, 4))
        begin
            run_len = $urandom_range(cap);
            // rare run past the cut-off of a mid-sized limit
            if (tracker.max_len >= 200 && tracker.max_len <= 300 && $urandom_range(29) == 0)
                run_len = tracker.max_len + $urandom_range(4);
            repeat (run_len) scan_bytes.push_back(rand_text());
            kind = $urandom_range(5);
            case (kind)
                0, 1:
                begin
                    scan_bytes.push_back(8'h00);
                    scan_bytes.push_back(byte_t'($urandom_range(255, 1)));
                    if ($urandom_range(3) == 0)
                        scan_bytes.push_back(byte_t'($urandom_range(255, 1)));
                    else
                        scan_bytes.push_back(8'h00);
                end
                2: scan_bytes.push_back(8'h00);
                3, 4: scan_bytes.push_back(rand_nontext());
                default: ;
            endcase
        end
        if (scan_bytes.size() == 0)
            scan_bytes.push_back(byte_t'($urandom));
    endfunction

    task automatic random_phase(input int n_items);
        int    sent;
        addr_t base;
        sent = 0;
        while (sent < n_items)
        begin
            fill_random_buffer();
            base = {$urandom, $urandom};
            if ($urandom_range(7) == 0)
                base = 64'hFFFF_FFFF_FFFF_FFF0 + addr_t'($urandom_range(15));
            else if ($urandom_range(7) == 0)
                base = addr_t'($urandom_range(15));
            send_buffer(base);
            sent += scan_bytes.size();
        end
    endtask

    initial
    begin
        clk                    = 1'b0;
        rst_n                  = 1'b0;
        quiet_cycles           = 0;
        send_idle_pct          = 25;
        recv_stall_pct         = 60;
        scan_ch.valid          = 1'b0;
        scan_ch.data_byte      = '0;
        scan_ch.byte_address   = '0;
        scan_ch.last_in_buffer = 1'b0;
        hit_ch.ready           = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = REG_MIN_LENGTH;
        cfg_ch.data            = '0;
        tracker                = new();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed buffers at reset limits
        // wide hit whose start address wraps below zero
        scan_bytes = '{8'h20, 8'h7E, 8'h09, 8'h00, 8'h41, 8'h00};
        send_buffer(64'h0);
        // narrow hit ended by delete, buffer crossing the top of the address space
        scan_bytes = '{8'h21, 8'h21, 8'h21, 8'h21, 8'h7F, 8'hFF};
        send_buffer(64'hFFFF_FFFF_FFFF_FFFC);
        // one- and two-byte buffers
        scan_bytes = '{8'h80};
        send_buffer({$urandom, $urandom});
        scan_bytes = '{8'h0A, 8'h1F};
        send_buffer({$urandom, $urandom});
        // run still open at buffer end is dropped
        scan_bytes = '{8'h08, 8'h62, 8'h63, 8'h64};
        send_buffer({$urandom, $urandom});
        // zero terminator as the final byte, no lookahead left
        scan_bytes = '{8'h78, 8'h79, 8'h7A, 8'h00};
        send_buffer({$urandom, $urandom});

        // random phases, one length setting each
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct  = 25;
                recv_stall_pct = 60;
            end
            else if (p < 6)
            begin
                send_idle_pct  = 60;
                recv_stall_pct = 25;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            drain();
            write_lengths(phase_min[p], phase_max[p]);
            random_phase(phase_items[p]);
        end

        drain();
        tracker.check_leftovers();
        $display("scanned %0d bytes over %0d length settings plus the reset limits",
                 tracker.n_bytes, PHASES);
        $display("compared %0d string hits, %0d of them wide", tracker.n_hits, tracker.n_wide);
        if (tracker.n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/pss_pkg.sv
hw/rtl/pss_if.sv
hw/rtl/printable_string_scanner_core.sv
dv/pss_scan_tb_pkg.sv
dv/tb_printable_string_scanner_core.sv
